### design/lfps_pkg.sv
// Package for the line-following PID steering block.
// Field widths, register indexes, reset values and limits; no dependencies.
`default_nettype none

package lfps_pkg;

  localparam int GAIN_BITS   = 16;
  localparam int TARGET_BITS = 12;
  localparam int SPEED_BITS  = 10;
  localparam int FLOOR_BITS  = 11;
  localparam int DRIVE_BITS  = 10;
  localparam int CORR_BITS   = 16;
  localparam int FRAC_BITS   = 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KP_GAIN      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KI_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KD_GAIN      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_LEVEL = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEER_SIGN   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USE_INTEGRAL = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDUP_FLOOR = 3'd7;

  // reset values
  localparam logic [GAIN_BITS-1:0]          KP_RESET     = 16'd256;
  localparam logic [GAIN_BITS-1:0]          KI_RESET     = 16'd0;
  localparam logic [GAIN_BITS-1:0]          KD_RESET     = 16'd0;
  localparam logic [TARGET_BITS-1:0]        TARGET_RESET = 12'd2048;
  localparam logic signed [SPEED_BITS-1:0]  SPEED_RESET  = 10'sd0;
  localparam logic signed [FLOOR_BITS-1:0]  FLOOR_RESET  = -11'sd10;

  // request action codes
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic signed [DRIVE_BITS-1:0] DRIVE_MAX = 10'sd500;
  localparam logic signed [DRIVE_BITS-1:0] DRIVE_MIN = -10'sd500;
  localparam logic signed [CORR_BITS-1:0]  CORR_MAX  = 16'sh7FFF;
  localparam logic signed [CORR_BITS-1:0]  CORR_MIN  = 16'sh8000;

endpackage

`default_nettype wire

### design/lfps_sensor_if.sv
// Sensor request channel: valid/ready with the action and sample fields.
// Does not depend on lfps_pkg; width follows SAMPLE_BITS.
`default_nettype none

interface lfps_sensor_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

### design/lfps_steer_if.sv
// Steering result channel: valid/ready with wheel commands and correction.
// Field widths come from lfps_pkg.
`default_nettype none

interface lfps_steer_if
  import lfps_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [DRIVE_BITS-1:0] left_drive;
  logic signed [DRIVE_BITS-1:0] right_drive;
  logic signed [CORR_BITS-1:0]  correction;
  logic                         windup_cleared;

  modport source (output valid, output left_drive, output right_drive,
                  output correction, output windup_cleared, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input correction, input windup_cleared, output ready);
endinterface

`default_nettype wire

### design/line_follow_pid_steer.sv
// PID steering for a line follower: one sensor request in, one wheel command out.
// The result is registered: the input register, then the result register.
// Throughput: one request per cycle while steer.ready does not stall the result register;
// the error sum and last error feed back through the integral multiply and windup compare.
// Reset (rst, synchronous): registers to defaults, error sum and last error to zero,
// both stages empty.
`default_nettype none

module line_follow_pid_steer
  import lfps_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_BITS    = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [CFG_DATA_BITS-1:0]    cfg_data,
  lfps_sensor_if.sink                sensor,
  lfps_steer_if.source               steer
);

  localparam int EW = ((SAMPLE_BITS > TARGET_BITS) ? SAMPLE_BITS : TARGET_BITS) + 1;
  localparam int AW = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;
  localparam int IW = SUM_BITS + GAIN_BITS + 1;
  localparam int PW = GAIN_BITS + EW + 1;
  localparam int DW = GAIN_BITS + EW + 2;
  localparam int TW = ((IW > DW) ? IW : DW) + 2;
  localparam int XW = CORR_BITS + 2;

  localparam logic signed [AW-1:0] SUM_MAX = AW'({1'b0, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [AW-1:0] SUM_MIN = ~SUM_MAX;

  // configuration registers
  logic [GAIN_BITS-1:0]          kp_gain;
  logic [GAIN_BITS-1:0]          ki_gain;
  logic [GAIN_BITS-1:0]          kd_gain;
  logic [TARGET_BITS-1:0]        target_level;
  logic signed [SPEED_BITS-1:0]  base_speed;
  logic                          steer_sign;
  logic                          use_integral;
  logic signed [FLOOR_BITS-1:0]  windup_floor;

  // loop state
  logic signed [SUM_BITS-1:0]    error_sum;
  logic signed [EW-1:0]          prev_error;

  // input stage
  logic                          s1_valid;
  logic                          s1_action;
  logic [SAMPLE_BITS-1:0]        s1_sample;

  // result stage
  logic                          o_valid;
  logic signed [DRIVE_BITS-1:0]  o_left;
  logic signed [DRIVE_BITS-1:0]  o_right;
  logic signed [CORR_BITS-1:0]   o_corr;
  logic                          o_cleared;

  logic                          adv;
  logic                          take;

  logic signed [EW-1:0]          err_c;
  logic signed [AW-1:0]          sum_wide;
  logic signed [SUM_BITS-1:0]    sum_sat;
  logic signed [IW-1:0]          i_q;
  logic signed [IW-1:0]          i_eff;
  logic signed [IW-1:0]          windup_lim;
  logic                          cleared_c;
  logic signed [PW-1:0]          p_q;
  logic signed [EW:0]            deriv;
  logic signed [DW-1:0]          d_q;
  logic signed [TW-1:0]          total_q;
  logic signed [TW-1:0]          shifted;
  logic signed [CORR_BITS-1:0]   corr_c;
  logic signed [XW-1:0]          plus_c;
  logic signed [XW-1:0]          minus_c;
  logic signed [DRIVE_BITS-1:0]  plus_sat;
  logic signed [DRIVE_BITS-1:0]  minus_sat;

  function automatic logic signed [DRIVE_BITS-1:0] sat_drive(
    input logic signed [XW-1:0] v
  );
    logic signed [DRIVE_BITS-1:0] r;
    if (v > XW'(DRIVE_MAX)) begin
      r = DRIVE_MAX;
    end else if (v < XW'(DRIVE_MIN)) begin
      r = DRIVE_MIN;
    end else begin
      r = v[DRIVE_BITS-1:0];
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= KP_RESET;
      ki_gain      <= KI_RESET;
      kd_gain      <= KD_RESET;
      target_level <= TARGET_RESET;
      base_speed   <= SPEED_RESET;
      steer_sign   <= 1'b0;
      use_integral <= 1'b1;
      windup_floor <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN:      kp_gain      <= cfg_data;
        REG_KI_GAIN:      ki_gain      <= cfg_data;
        REG_KD_GAIN:      kd_gain      <= cfg_data;
        REG_TARGET_LEVEL: target_level <= cfg_data[TARGET_BITS-1:0];
        REG_BASE_SPEED:   base_speed   <= $signed(cfg_data[SPEED_BITS-1:0]);
        REG_STEER_SIGN:   steer_sign   <= cfg_data[0];
        REG_USE_INTEGRAL: use_integral <= cfg_data[0];
        REG_WINDUP_FLOOR: windup_floor <= $signed(cfg_data[FLOOR_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // handshake: advance the input stage whenever the result register frees up
  assign take         = sensor.valid && sensor.ready;
  assign adv          = s1_valid && (!o_valid || steer.ready);
  assign sensor.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_action <= sensor.action;
      s1_sample <= sensor.sample;
    end
  end

  // datapath
  always_comb begin
    err_c = $signed({{(EW-TARGET_BITS){1'b0}}, target_level})
          - $signed({{(EW-SAMPLE_BITS){1'b0}}, s1_sample});

    sum_wide = AW'(error_sum) + AW'(err_c);
    if (sum_wide > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_BITS-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_BITS-1:0];
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end

    i_q        = $signed({1'b0, ki_gain}) * sum_sat;
    windup_lim = IW'($signed({windup_floor, {FRAC_BITS{1'b0}}}));
    cleared_c  = i_q < windup_lim;
    i_eff      = (cleared_c || !use_integral) ? '0 : i_q;

    p_q   = $signed({1'b0, kp_gain}) * err_c;
    deriv = (EW+1)'(prev_error) - (EW+1)'(err_c);
    d_q   = $signed({1'b0, kd_gain}) * deriv;

    total_q = TW'(p_q) + TW'(d_q) + TW'(i_eff);
    shifted = total_q >>> FRAC_BITS;
    if (shifted > TW'(CORR_MAX)) begin
      corr_c = CORR_MAX;
    end else if (shifted < TW'(CORR_MIN)) begin
      corr_c = CORR_MIN;
    end else begin
      corr_c = shifted[CORR_BITS-1:0];
    end

    plus_c    = XW'(base_speed) + XW'(corr_c);
    minus_c   = XW'(base_speed) - XW'(corr_c);
    plus_sat  = sat_drive(plus_c);
    minus_sat = sat_drive(minus_c);
  end

  // loop state follows the request leaving the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      prev_error <= '0;
    end else if (adv) begin
      if (s1_action == ACT_RESTART) begin
        error_sum  <= '0;
        prev_error <= '0;
      end else begin
        error_sum  <= cleared_c ? '0 : sum_sat;
        prev_error <= err_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (steer.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_action == ACT_RESTART) begin
        o_left    <= '0;
        o_right   <= '0;
        o_corr    <= '0;
        o_cleared <= 1'b0;
      end else begin
        o_left    <= steer_sign ? minus_sat : plus_sat;
        o_right   <= steer_sign ? plus_sat : minus_sat;
        o_corr    <= corr_c;
        o_cleared <= cleared_c;
      end
    end
  end

  assign steer.valid          = o_valid;
  assign steer.left_drive     = o_left;
  assign steer.right_drive    = o_right;
  assign steer.correction     = o_corr;
  assign steer.windup_cleared = o_cleared;

`ifndef SYNTH
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_left <= DRIVE_MAX && o_left >= DRIVE_MIN &&
                 o_right <= DRIVE_MAX && o_right >= DRIVE_MIN))
    else $error("wheel command outside limit");

  a_windup_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_action == ACT_SAMPLE && cleared_c) |=> (error_sum == '0 && o_cleared))
    else $error("windup did not clear the error sum");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_action == ACT_RESTART) |=>
      (error_sum == '0 && prev_error == '0 && o_corr == '0 && !o_cleared))
    else $error("restart left state or result non-zero");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_sample) && $stable(s1_action)))
    else $error("input stage lost a pending request");
`endif

endmodule

`default_nettype wire
